[src/tar_pkg.sv]
// package: shared constants, types and codes for the tile animation rewriter
package tar_pkg;

  localparam int MaxEntriesDef  = 32;
  localparam int ScriptDepthDef = 1024;
  localparam int TileShiftDef   = 7;
  localparam int RowShiftDef    = 3;

  localparam logic [15:0] END_MARK = 16'hFFFF;
  localparam logic [15:0] TILE_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_WRITE  = 2'd2,
    FN_LOAD   = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_ACTIVE = 1'b0,
    CFG_LAYER  = 1'b1
  } cfg_idx_t;

  // queued command from the front part to the back part
  typedef struct packed {
    func_t       func;
    logic [1:0]  layer;
    logic [16:0] idx;
    logic [15:0] addr;
    logic [15:0] wval;
    logic [5:0]  slot;
    logic [15:0] target;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD_RD0,
    ST_LOAD_RD1,
    ST_LOAD_W0,
    ST_LOAD_W1,
    ST_TICK_NEXT,
    ST_TICK_RDP,
    ST_TICK_CHK,
    ST_TICK_RD1,
    ST_TICK_W0,
    ST_TICK_W1,
    ST_OUT
  } state_t;

endpackage

[src/tar_ram.sv]
// generic single port ram with registered read
module tar_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/tar_front.sv]
// front part: takes input words, forms the tile index, queues commands
module tar_front import tar_pkg::*; #(
  parameter int TileShift = TileShiftDef,
  parameter int RowShift  = RowShiftDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  layer,
  input  logic [12:0] pos_x,
  input  logic [12:0] pos_y,
  input  logic [14:0] tile_base,
  input  logic [9:0]  word_addr,
  input  logic [15:0] word_value,
  input  logic [4:0]  entry_slot,
  input  logic [15:0] target_tile,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);
  // two entry queue
  cmd_t       slot0, slot1;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic [16:0] row_part, col_part;
  logic       push, pop;

  always_comb begin
    row_part = 17'(({4'd0, pos_y} >> TileShift) << RowShift);
    col_part = 17'({4'd0, pos_x} >> TileShift);
    cmd_in.func   = func_t'(func);
    cmd_in.layer  = layer;
    cmd_in.idx    = row_part + col_part + {2'd0, tile_base};
    cmd_in.addr   = {6'd0, word_addr};
    cmd_in.wval   = word_value;
    cmd_in.slot   = {1'b0, entry_slot};
    cmd_in.target = target_tile;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (pop) begin
      slot0 <= (fill == 2'd2) ? slot1 : cmd_in;
      if (push && fill == 2'd2) slot1 <= cmd_in;
    end else if (push) begin
      if (fill == 2'd0) slot0 <= cmd_in;
      else slot1 <= cmd_in;
    end
  end
endmodule

[src/tar_back.sv]
// back part: script memory, entry table, tick walk, lookup scan and loads
module tar_back import tar_pkg::*; #(
  parameter int MaxEntries  = MaxEntriesDef,
  parameter int ScriptDepth = ScriptDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [5:0]  active_entries,
  input  logic [3:0]  layer_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tile_index,
  output logic        replaced
);
  localparam int AW = $clog2(ScriptDepth);
  localparam int EW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries + 1);

  logic [1:0]  e_layer   [MaxEntries];
  logic [15:0] e_target  [MaxEntries];
  logic [AW-1:0] e_start [MaxEntries];
  logic [AW-1:0] e_ptr   [MaxEntries];
  logic [15:0] e_count   [MaxEntries];
  logic [15:0] e_cur     [MaxEntries];

  state_t state, state_next;
  cmd_t   cmd;
  logic [CW-1:0] idx;     // entry walk counter
  logic [CW-1:0] n_used;
  logic [AW-1:0] raddr;
  logic [15:0]   word0;
  logic [AW-1:0] base_addr;
  logic [15:0]   cnt_dec;
  logic [15:0]   ram_q;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] eidx;
  logic [15:0]   res_tile;
  logic          res_rep;

  assign n_used = ({1'b0, active_entries} > 7'(MaxEntries)) ? CW'(MaxEntries) :
                  CW'(active_entries);
  assign eidx   = (cmd.func == FN_LOAD) ? EW'(cmd.slot) : EW'(idx);
  assign cnt_dec = e_count[eidx] - 16'd1;

  // writes only happen in idle, straight from the queue head
  tar_ram #(.Width(16), .Depth(ScriptDepth)) u_script (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(q_cmd.wval), .rdata(ram_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) begin
        case (q_cmd.func)
          FN_TICK:   state_next = ST_TICK_NEXT;
          FN_LOOKUP: state_next = ST_SCAN;
          FN_WRITE:  state_next = ST_IDLE;
          default:   state_next = ({1'b0, q_cmd.slot} < 7'(MaxEntries)) ? ST_LOAD_RD0 : ST_IDLE;
        endcase
      end
      ST_SCAN: if (idx >= n_used || res_rep) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      ST_LOAD_RD0: state_next = ST_LOAD_RD1;
      ST_LOAD_RD1: state_next = ST_LOAD_W0;
      ST_LOAD_W0:  state_next = ST_LOAD_W1;
      ST_LOAD_W1:  state_next = (cmd.func == FN_LOAD) ? ST_IDLE : ST_TICK_NEXT;
      ST_TICK_NEXT: begin
        if (idx >= n_used) state_next = ST_IDLE;
        else if (cnt_dec == 16'd0) state_next = ST_TICK_RDP;
      end
      ST_TICK_RDP: state_next = ST_TICK_CHK;
      ST_TICK_CHK: state_next = ST_LOAD_RD0;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory address and write control
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = raddr;
    case (state)
      ST_IDLE: begin
        ram_addr = AW'(q_cmd.addr);
        ram_we   = q_valid && (q_cmd.func == FN_WRITE);
      end
      ST_LOAD_RD0: ram_addr = base_addr;
      ST_LOAD_RD1: ram_addr = base_addr + AW'(1);
      ST_TICK_RDP: ram_addr = e_ptr[eidx];
      default: ram_addr = raddr;
    endcase
  end

  assign q_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign tile_index = res_tile;
  assign replaced = res_rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < MaxEntries; i++) begin
        e_layer[i] <= '0; e_target[i] <= '0; e_start[i] <= '0;
        e_ptr[i] <= '0; e_count[i] <= '0; e_cur[i] <= '0;
      end
    end else begin
      state <= state_next;
      raddr <= ram_addr;
      case (state)
        ST_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          idx <= '0;
          base_addr <= AW'(q_cmd.addr);
          res_rep <= 1'b0;
          res_tile <= (q_cmd.idx > 17'(TILE_MAX)) ? TILE_MAX : q_cmd.idx[15:0];
        end
        ST_SCAN: if (!res_rep && idx < n_used) begin
          // lowest matching entry wins
          if (layer_enable[cmd.layer] && e_layer[EW'(idx)] == cmd.layer &&
              {{1{e_target[EW'(idx)][15]}}, e_target[EW'(idx)]} == cmd.idx) begin
            res_rep  <= 1'b1;
            res_tile <= e_cur[EW'(idx)];
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_LOAD_RD0: if (cmd.func == FN_LOAD) begin
          e_layer[eidx]  <= cmd.layer;
          e_target[eidx] <= cmd.target;
          e_start[eidx]  <= base_addr;
        end
        // count word is back from the read issued in ST_LOAD_RD0
        ST_LOAD_RD1: word0 <= ram_q;
        ST_LOAD_W1: begin
          e_count[eidx] <= word0;
          e_cur[eidx]   <= ram_q;
          e_ptr[eidx]   <= base_addr + AW'(2);
          if (cmd.func != FN_LOAD) idx <= idx + CW'(1);
        end
        ST_TICK_NEXT: if (idx < n_used) begin
          e_count[eidx] <= cnt_dec;
          if (cnt_dec != 16'd0) idx <= idx + CW'(1);
        end
        ST_TICK_CHK: begin
          base_addr <= (ram_q == END_MARK) ? e_start[eidx] : e_ptr[eidx];
        end
        default: ;
      endcase
    end
  end
endmodule

[src/tile_animation_rewriter.sv]
// Tile animation rewriter: each input word enters a two deep command queue; the
// back part runs one command at a time. A script write is done from idle, an entry
// load reads the count and tile words through the single script memory port, a
// lookup scans the active entries one per cycle up to and including the first match
// (all active entries when none matches), and a tick walks the active entries one
// per cycle, pausing to reload each entry whose count expires from the script
// memory. Lookup results wait in the output register, holding the back part.
module tile_animation_rewriter import tar_pkg::*; #(
  parameter int MaxEntries  = MaxEntriesDef,
  parameter int ScriptDepth = ScriptDepthDef,
  parameter int TileShift   = TileShiftDef,
  parameter int RowShift    = RowShiftDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  layer,
  input  logic [12:0] pos_x,
  input  logic [12:0] pos_y,
  input  logic [14:0] tile_base,
  input  logic [9:0]  word_addr,
  input  logic [15:0] word_value,
  input  logic [4:0]  entry_slot,
  input  logic [15:0] target_tile,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tile_index,
  output logic        replaced
);
  logic [5:0] active_entries;
  logic [3:0] layer_enable;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
      layer_enable   <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE: active_entries <= cfg_data;
        CFG_LAYER:  layer_enable   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tar_front #(.TileShift(TileShift), .RowShift(RowShift)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .layer, .pos_x, .pos_y, .tile_base,
    .word_addr, .word_value, .entry_slot, .target_tile,
    .q_valid, .q_ready, .q_cmd
  );

  tar_back #(.MaxEntries(MaxEntries), .ScriptDepth(ScriptDepth)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .active_entries, .layer_enable,
    .out_valid, .out_ready, .tile_index, .replaced
  );
endmodule

[src/tar_checker.sv]
// port level checks for the tile animation rewriter
module tar_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tile_index,
  input logic        replaced
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tile_index) && $stable(replaced))
    else $error("result word changed while stalled");
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid && in_ready)
    else $error("not idle right after reset");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !replaced |-> !tile_index[15])
    else $error("unreplaced index not saturated");
endmodule

bind tile_animation_rewriter tar_checker u_tar_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .tile_index, .replaced
);

[sim/tile_animation_rewriter_check.sv]
// checker: predicts tile lookups from the accepted words and compares the results
`timescale 1ns / 1ps
module tile_animation_rewriter_check import tar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  layer,
  input  logic [12:0] pos_x,
  input  logic [12:0] pos_y,
  input  logic [14:0] tile_base,
  input  logic [9:0]  word_addr,
  input  logic [15:0] word_value,
  input  logic [4:0]  entry_slot,
  input  logic [15:0] target_tile,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] tile_index,
  input  logic        replaced,
  output int          errors,
  output int          pending
);

  localparam int NumEntries = MaxEntriesDef;
  localparam int Depth      = ScriptDepthDef;

  typedef struct packed {
    logic [15:0] tile;
    logic        rep;
  } tile_result_t;

  tile_result_t tile_expect_q[$];

  logic [15:0] script_img [Depth];
  logic [1:0]  ent_layer  [NumEntries];
  logic [15:0] ent_target [NumEntries];
  logic [9:0]  ent_start  [NumEntries];
  logic [9:0]  ent_ptr    [NumEntries];
  logic [15:0] ent_count  [NumEntries];
  logic [15:0] ent_tile   [NumEntries];
  logic [5:0]  num_active;
  logic [3:0]  layer_on;

  assign pending = tile_expect_q.size();

  function automatic int entries_used();
    return (num_active > NumEntries) ? NumEntries : int'(num_active);
  endfunction

  function automatic void fetch_pair(int e, logic [9:0] a);
    ent_count[e] = script_img[a];
    ent_tile[e]  = script_img[10'(a + 1)];
    ent_ptr[e]   = 10'(a + 2);
  endfunction

  function automatic void apply_word();
    int n;
    int idx;
    tile_result_t r;
    n = entries_used();
    case (func_t'(func))
      FN_TICK: begin
        for (int i = 0; i < n; i++) begin
          ent_count[i] = ent_count[i] - 16'd1;
          if (ent_count[i] == 16'd0) begin
            if (script_img[ent_ptr[i]] == END_MARK) fetch_pair(i, ent_start[i]);
            else fetch_pair(i, ent_ptr[i]);
          end
        end
      end
      FN_LOOKUP: begin
        idx = ((int'(pos_y) >> TileShiftDef) << RowShiftDef) + (int'(pos_x) >> TileShiftDef)
              + int'(tile_base);
        r.tile = (idx > 32767) ? TILE_MAX : 16'(idx);
        r.rep  = 1'b0;
        if (layer_on[layer]) begin
          for (int i = 0; i < n; i++) begin
            if (ent_layer[i] == layer && int'($signed(ent_target[i])) == idx) begin
              r.tile = ent_tile[i];
              r.rep  = 1'b1;
              break;
            end
          end
        end
        tile_expect_q.push_back(r);
      end
      FN_WRITE: script_img[word_addr] = word_value;
      default: begin
        ent_layer[entry_slot]  = layer;
        ent_target[entry_slot] = target_tile;
        ent_start[entry_slot]  = word_addr;
        fetch_pair(entry_slot, word_addr);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tile_result_t want;
    if (rst) begin
      errors = 0;
      tile_expect_q.delete();
      for (int i = 0; i < Depth; i++) script_img[i] = '0;
      for (int i = 0; i < NumEntries; i++) begin
        ent_layer[i] = '0; ent_target[i] = '0; ent_start[i] = '0;
        ent_ptr[i] = '0; ent_count[i] = '0; ent_tile[i] = '0;
      end
      num_active = '0;
      layer_on   = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (tile_expect_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result word: tile %0d replaced %0b",
                                     $signed(tile_index), replaced);
        end else begin
          want = tile_expect_q.pop_front();
          if (want.tile !== tile_index || want.rep !== replaced) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: expected tile %0d replaced %0b, got tile %0d replaced %0b",
                       $signed(want.tile), want.rep, $signed(tile_index), replaced);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_ACTIVE) num_active = cfg_data;
        else layer_on = cfg_data[3:0];
      end
      if (in_valid && in_ready) apply_word();
    end
  end

endmodule

[sim/tile_animation_rewriter_test.sv]
// testbench top: drives scripts, entry loads, ticks and lookups into the rewriter
`timescale 1ns / 1ps
module tile_animation_rewriter_test;
  import tar_pkg::*;

  localparam int NumItems   = 1250;
  localparam int CycleLimit = 2000000;

  typedef struct {
    func_t       f;
    logic [1:0]  ly;
    logic [12:0] x;
    logic [12:0] y;
    logic [14:0] base;
    logic [9:0]  addr;
    logic [15:0] wval;
    logic [4:0]  slot;
    logic [15:0] target;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [1:0]  layer = '0;
  logic [12:0] pos_x = '0;
  logic [12:0] pos_y = '0;
  logic [14:0] tile_base = '0;
  logic [9:0]  word_addr = '0;
  logic [15:0] word_value = '0;
  logic [4:0]  entry_slot = '0;
  logic [15:0] target_tile = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] tile_index;
  logic        replaced;
  int          errors;
  int          pending;

  int          cycles = 0;
  int          items = 0;
  bit          calm = 1'b0;
  int          ready_hold = 0;

  // script slots: fixed start per slot, nothing outside them is ever read
  logic [9:0]  slot_start [16];
  bit          slot_done  [16];
  bit          ent_loaded [32];
  logic [1:0]  ent_layer  [32];
  logic [15:0] ent_target [32];

  always #10 clk = ~clk;

  tile_animation_rewriter dut (.*);

  tile_animation_rewriter_check checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls in random stretches
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  function automatic word_t rand_word(func_t f);
    word_t w;
    w.f = f;
    w.ly = 2'($urandom);
    w.x = 13'($urandom);
    w.y = 13'($urandom);
    w.base = 15'($urandom);
    w.addr = 10'($urandom);
    w.wval = 16'($urandom);
    w.slot = 5'($urandom);
    w.target = 16'($urandom);
    return w;
  endfunction

  task automatic push_word(word_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    func = w.f; layer = w.ly; pos_x = w.x; pos_y = w.y; tile_base = w.base;
    word_addr = w.addr; word_value = w.wval; entry_slot = w.slot; target_tile = w.target;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // up to three ticks may still be queued or running, each with every entry expiring
    repeat (1000) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [5:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_script(int s, int pairs);
    word_t w;
    logic [9:0] a;
    a = slot_start[s];
    for (int p = 0; p < pairs; p++) begin
      w = rand_word(FN_WRITE);
      w.addr = a;
      w.wval = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      push_word(w);
      w = rand_word(FN_WRITE);
      w.addr = 10'(a + 1);
      if ($urandom_range(0, 1)) w.wval = 16'($urandom_range(0, 4000));
      push_word(w);
      a = 10'(a + 2);
    end
    w = rand_word(FN_WRITE);
    w.addr = a;
    w.wval = END_MARK;
    push_word(w);
    slot_done[s] = 1'b1;
  endtask

  task automatic load_entry(int e, int s, logic [1:0] ly, logic [15:0] tgt);
    word_t w;
    w = rand_word(FN_LOAD);
    w.slot = 5'(e);
    w.addr = slot_start[s];
    w.ly = ly;
    w.target = tgt;
    push_word(w);
    ent_loaded[e] = 1'b1;
    ent_layer[e]  = ly;
    ent_target[e] = tgt;
  endtask

  // lookup aimed at the target of a loaded entry when one can be reached
  task automatic lookup_hit(int e);
    word_t w;
    int part;
    w = rand_word(FN_LOOKUP);
    w.ly = ent_layer[e];
    if (!ent_target[e][15]) begin
      part = ((int'(w.y) >> TileShiftDef) << RowShiftDef) + (int'(w.x) >> TileShiftDef);
      if (part > int'(ent_target[e])) begin
        w.x = 13'($urandom_range(0, 127));
        w.y = 13'($urandom_range(0, 127));
        part = 0;
      end
      w.base = 15'(int'(ent_target[e]) - part);
    end
    push_word(w);
  endtask

  task automatic tick();
    push_word(rand_word(FN_TICK));
  endtask

  initial begin
    word_t w;
    int e;
    int s;
    int r;
    int next_cfg;
    for (int i = 0; i < 16; i++) begin
      slot_start[i] = 10'(i * 64 + 52 + $urandom_range(0, 8));
      slot_done[i]  = 1'b0;
    end
    slot_start[15] = 10'd1020;  // this script can wrap past the top address
    for (int i = 0; i < 32; i++) ent_loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    write_reg(CFG_ACTIVE, 6'd32);
    write_reg(CFG_LAYER, 6'd15);
    write_script(0, 2);
    write_script(15, 2);
    load_entry(0, 0, 2'd0, 16'd0);
    load_entry(31, 15, 2'd3, 16'h7FFF);
    load_entry(1, 15, 2'd0, 16'd0);
    load_entry(2, 0, 2'd1, 16'h8000);
    w = rand_word(FN_LOOKUP);
    w.ly = 2'd0; w.x = '0; w.y = '0; w.base = '0;
    push_word(w);
    w.ly = 2'd3; w.x = 13'h1FFF; w.y = 13'h1FFF; w.base = 15'h7FFF;
    push_word(w);
    w.ly = 2'd3; w.x = '0; w.y = '0;
    push_word(w);
    repeat (3) tick();
    lookup_hit(0);
    lookup_hit(31);
    w = rand_word(FN_WRITE);
    w.addr = 10'd20; w.wval = 16'h8000;
    push_word(w);
    drain();
    write_reg(CFG_LAYER, 6'd0);
    lookup_hit(0);
    drain();
    write_reg(CFG_ACTIVE, 6'd63);
    write_reg(CFG_LAYER, 6'd15);

    // random part
    next_cfg = items + $urandom_range(100, 200);
    while (items < NumItems) begin
      if (items >= next_cfg) begin
        drain();
        calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 5);
        write_reg(CFG_ACTIVE, (r == 0) ? 6'd0 : (r == 1) ? 6'd1 : (r == 2) ? 6'd32 :
                              (r == 3) ? 6'd33 : (r == 4) ? 6'd63 : 6'($urandom_range(0, 63)));
        r = $urandom_range(0, 3);
        write_reg(CFG_LAYER, (r == 0) ? 6'd15 : (r == 1) ? 6'd0 : 6'($urandom_range(0, 15)));
        next_cfg = items + $urandom_range(100, 200);
      end
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 15);
      e = $urandom_range(0, 31);
      if (r < 10) begin
        write_script(s, $urandom_range(1, 8));
      end else if (r < 28) begin
        if (slot_done[s])
          load_entry(e, s, 2'($urandom),
                     ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
        else write_script(s, $urandom_range(1, 8));
      end else if (r < 55) begin
        if (ent_loaded[e] && $urandom_range(0, 3) != 0) lookup_hit(e);
        else push_word(rand_word(FN_LOOKUP));
      end else if (r < 93) begin
        tick();
      end else begin
        // noise into the unused gap between scripts
        w = rand_word(FN_WRITE);
        w.addr = 10'($urandom_range(0, 15) * 64 + $urandom_range(14, 51));
        push_word(w);
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
